// File: rtl/core/lcrma_pkg.sv
// Shared types, constants and helpers for the load cell reader with moving average.
package lcrma_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int FILTER_DEPTH = 16;
  localparam int RING_AW      = $clog2(FILTER_DEPTH);
  localparam int SUM_W        = SAMPLE_BITS + RING_AW;
  localparam int BIT_CNT_W    = $clog2(SAMPLE_BITS + 2);
  localparam int RES_W        = 34;
  localparam int WIDE_W       = 36;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_GAIN    = 3'd4;

  localparam logic [7:0]         RST_HALF_PERIOD   = 8'd1;
  localparam logic [23:0]        RST_REPORT_PERIOD = 24'd100000;
  localparam logic signed [23:0] RST_SLOPE         = -24'sd280180;
  localparam logic signed [31:0] RST_OFFSET        = 32'sd52071424;
  localparam logic [23:0]        RST_FORCE_GAIN    = 24'd164584;

  typedef struct packed {
    logic                   clock_level;
    logic [SAMPLE_BITS-1:0] raw_nxt;
  } cap_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } flt_stat_t;

  function automatic logic signed [RES_W-1:0] sat_res(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    logic signed [RES_W-1:0]  r;
    hi = {{(WIDE_W-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}};
    lo = {{(WIDE_W-RES_W+1){1'b1}}, {(RES_W-1){1'b0}}};
    if (v > hi) begin
      r = {1'b0, {(RES_W-1){1'b1}}};
    end else if (v < lo) begin
      r = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      r = v[RES_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/load_cell_reader_moving_average.sv
// Load cell converter reader with 16-entry moving average and weight/force scaling.
//
// Each beat on the in_ channel is one tick carrying the sampled converter data
// line. Each accepted beat yields exactly one beat on the out_ channel with the
// clock line level for that tick, the latest 24-bit conversion and the held
// filtered, weight and force values; out_report_valid marks a filter update.
// Timing: an ordinary tick is registered at the edge that takes it and can
// leave in the next cycle; the next tick can be taken in that same cycle. A report
// tick reads the history ring RAM, updates the sum and runs two multiply
// stages; its result is registered once the filter is done and the output
// register is free, with in_stall held high meanwhile. Throughput: one tick per
// cycle while nothing stalls; no tick is taken while a report tick is in flight.
// If out_stall is high while a result is held, in_stall rises and no tick is
// taken until that result moves on. Reset (synchronous, rst_n low) restores
// the register defaults, clears the capture state, the running sum and the
// ring (read as zero until written) and empties the output register.
// Configuration beats on cfg_ are always taken; write them only while idle.
module load_cell_reader_moving_average (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_data_pin,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_clock_pin,
  output logic                                out_report_valid,
  output logic [23:0]                         out_raw_value,
  output logic [23:0]                         out_filtered_value,
  output logic signed [33:0]                  out_weight_q8,
  output logic signed [33:0]                  out_force_q8,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcrma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                         cfg_data
);
  import lcrma_pkg::*;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_BUSY = 2'd1;
  localparam logic [1:0] T_OUT  = 2'd2;

  logic [7:0]         half_period_r;
  logic [23:0]        report_period_r;
  logic signed [23:0] slope_r;
  logic signed [31:0] offset_r;
  logic [23:0]        gain_r;

  logic [1:0]  tstate_r;
  logic [23:0] countdown_r;
  logic        pend_clk_r;
  logic [23:0] pend_raw_r;

  logic                    out_valid_r;
  logic                    out_clock_r;
  logic                    out_report_r;
  logic [23:0]             out_raw_r;
  logic [23:0]             out_filtered_r;
  logic signed [RES_W-1:0] out_weight_r;
  logic signed [RES_W-1:0] out_force_r;

  cap_out_t                cap;
  flt_stat_t               flt_st;
  logic [23:0]             flt_filtered;
  logic signed [RES_W-1:0] flt_weight;
  logic signed [RES_W-1:0] flt_force;

  logic out_free;
  logic accept;
  logic report;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (tstate_r != T_IDLE) || flt_st.busy || !out_free;
  assign accept    = in_valid && !in_stall;
  assign report    = (countdown_r <= 24'd1);
  assign cfg_ready = 1'b1;

  lcrma_capture u_capture (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (accept),
    .data_pin    (in_data_pin),
    .half_period (half_period_r),
    .cap         (cap)
  );

  lcrma_filter u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept && report),
    .raw       (pend_raw_r),
    .slope     (slope_r),
    .offset    (offset_r),
    .gain      (gain_r),
    .st        (flt_st),
    .filtered  (flt_filtered),
    .weight    (flt_weight),
    .force_val (flt_force)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r   <= RST_HALF_PERIOD;
      report_period_r <= RST_REPORT_PERIOD;
      slope_r         <= RST_SLOPE;
      offset_r        <= RST_OFFSET;
      gain_r          <= RST_FORCE_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HALF_PERIOD:   half_period_r   <= cfg_data[7:0];
        CFG_REPORT_PERIOD: report_period_r <= cfg_data[23:0];
        CFG_SLOPE:         slope_r         <= cfg_data[23:0];
        CFG_OFFSET:        offset_r        <= cfg_data;
        CFG_FORCE_GAIN:    gain_r          <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tstate_r    <= T_IDLE;
      countdown_r <= RST_REPORT_PERIOD;
      out_valid_r <= 1'b0;
    end else begin
      if ((accept && !report) || (tstate_r == T_OUT && out_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        if (report) begin
          countdown_r <= (report_period_r == 24'd0) ? 24'd1 : report_period_r;
          tstate_r    <= T_BUSY;
        end else begin
          countdown_r <= countdown_r - 24'd1;
        end
      end
      unique case (tstate_r)
        T_BUSY: if (flt_st.done) tstate_r <= T_OUT;
        T_OUT: begin
          if (out_free) begin
            tstate_r <= T_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_clk_r <= cap.clock_level;
      pend_raw_r <= cap.raw_nxt;
      if (!report) begin
        out_clock_r    <= cap.clock_level;
        out_report_r   <= 1'b0;
        out_raw_r      <= cap.raw_nxt;
        out_filtered_r <= flt_filtered;
        out_weight_r   <= flt_weight;
        out_force_r    <= flt_force;
      end
    end else if (tstate_r == T_OUT && out_free) begin
      out_clock_r    <= pend_clk_r;
      out_report_r   <= 1'b1;
      out_raw_r      <= pend_raw_r;
      out_filtered_r <= flt_filtered;
      out_weight_r   <= flt_weight;
      out_force_r    <= flt_force;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_clock_pin      = out_clock_r;
  assign out_report_valid   = out_report_r;
  assign out_raw_value      = out_raw_r;
  assign out_filtered_value = out_filtered_r;
  assign out_weight_q8      = out_weight_r;
  assign out_force_q8       = out_force_r;

`ifndef SYNTHESIS
  a_report_starts_filter: assert property (@(posedge clk) disable iff (!rst_n)
    accept && report |=> flt_st.busy && tstate_r == T_BUSY)
    else $error("report tick did not start the filter");
  a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    flt_st.done |-> tstate_r == T_BUSY)
    else $error("filter finished with no report pending");
`endif

endmodule

// File: rtl/core/lcrma_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module lcrma_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/lcrma_capture.sv
// Serial converter front end: start edge detect, clock pulse generation, bit capture.
module lcrma_capture (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tick,
  input  logic               data_pin,
  input  logic [7:0]         half_period,
  output lcrma_pkg::cap_out_t cap
);
  import lcrma_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  logic [1:0]             phase_r, phase_nxt;
  logic [7:0]             half_cnt_r, half_cnt_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [SAMPLE_BITS-1:0] shift_r, shift_nxt;
  logic [SAMPLE_BITS-1:0] raw_r, raw_nxt;
  logic                   prev_r;

  logic [7:0]           half;
  logic [8:0]           cnt_inc;
  logic                 half_end;
  logic [BIT_CNT_W-1:0] bit_inc;

  assign half     = (half_period == 8'd0) ? 8'd1 : half_period;
  assign cnt_inc  = {1'b0, half_cnt_r} + 9'd1;
  assign half_end = (cnt_inc >= {1'b0, half});
  assign bit_inc  = bit_cnt_r + BIT_CNT_W'(1);

  always_comb begin
    phase_nxt    = phase_r;
    half_cnt_nxt = half_cnt_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    raw_nxt      = raw_r;
    unique case (phase_r)
      PH_LOW: begin
        half_cnt_nxt = cnt_inc[7:0];
        if (half_end) begin
          half_cnt_nxt = 8'd0;
          phase_nxt    = PH_HIGH;
        end
      end
      PH_HIGH: begin
        half_cnt_nxt = cnt_inc[7:0];
        if (half_end) begin
          half_cnt_nxt = 8'd0;
          if (bit_cnt_r < BIT_CNT_W'(SAMPLE_BITS)) begin
            shift_nxt = {shift_r[SAMPLE_BITS-2:0], data_pin};
          end
          if (bit_inc >= BIT_CNT_W'(SAMPLE_BITS + 1)) begin
            raw_nxt     = shift_nxt;
            bit_cnt_nxt = '0;
            phase_nxt   = PH_IDLE;
          end else begin
            bit_cnt_nxt = bit_inc;
            phase_nxt   = PH_LOW;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (prev_r && !data_pin) begin
          phase_nxt    = PH_LOW;
          half_cnt_nxt = 8'd0;
          bit_cnt_nxt  = '0;
          shift_nxt    = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      half_cnt_r <= 8'd0;
      bit_cnt_r  <= '0;
      shift_r    <= '0;
      raw_r      <= '0;
      prev_r     <= 1'b0;
    end else if (tick) begin
      phase_r    <= phase_nxt;
      half_cnt_r <= half_cnt_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      raw_r      <= raw_nxt;
      prev_r     <= data_pin;
    end
  end

  assign cap.clock_level = (phase_r == PH_HIGH);
  assign cap.raw_nxt     = raw_nxt;

`ifndef SYNTHESIS
  a_idle_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> bit_cnt_r == '0)
    else $error("bit counter not clear while idle");
`endif

endmodule

// File: rtl/core/lcrma_filter.sv
// Moving-average ring in RAM plus fixed-point weight and force scaling pipeline.
module lcrma_filter (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic [lcrma_pkg::SAMPLE_BITS-1:0]       raw,
  input  logic signed [23:0]                      slope,
  input  logic signed [31:0]                      offset,
  input  logic [23:0]                             gain,
  output lcrma_pkg::flt_stat_t                    st,
  output logic [lcrma_pkg::SAMPLE_BITS-1:0]       filtered,
  output logic signed [lcrma_pkg::RES_W-1:0]      weight,
  output logic signed [lcrma_pkg::RES_W-1:0]      force_val
);
  import lcrma_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SUM  = 3'd1;
  localparam logic [2:0] F_MUL1 = 3'd2;
  localparam logic [2:0] F_WGT  = 3'd3;
  localparam logic [2:0] F_MUL2 = 3'd4;
  localparam logic [2:0] F_FRC  = 3'd5;

  logic [2:0]               fstate_r, fstate_nxt;
  logic [RING_AW-1:0]       pos_r;
  logic [FILTER_DEPTH-1:0]  valid_r;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0]   filtered_r;
  logic signed [48:0]       prod1_r;
  logic signed [58:0]       prod2_r;
  logic signed [RES_W-1:0]  weight_r, force_r;

  logic [SAMPLE_BITS-1:0]   rd_data;
  logic [SAMPLE_BITS-1:0]   old_val;
  logic signed [48:0]       rnd1;
  logic signed [58:0]       rnd2;
  logic signed [WIDE_W-1:0] wsum;
  logic signed [WIDE_W-1:0] fval;

  lcrma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (FILTER_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (fstate_r == F_SUM),
    .wr_addr (pos_r),
    .wr_data (raw),
    .rd_en   (start),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  // entries never written read as zero
  assign old_val = valid_r[pos_r] ? rd_data : '0;
  assign sum_nxt = sum_r - {{RING_AW{1'b0}}, old_val} + {{RING_AW{1'b0}}, raw};

  assign rnd1 = prod1_r + 49'sd32768;
  assign wsum = {{3{rnd1[48]}}, rnd1[48:16]} + {{4{offset[31]}}, offset};
  assign rnd2 = prod2_r + 59'sd8388608;
  assign fval = {rnd2[58], rnd2[58:24]};

  always_comb begin
    fstate_nxt = fstate_r;
    unique case (fstate_r)
      F_IDLE:  if (start) fstate_nxt = F_SUM;
      F_SUM:   fstate_nxt = F_MUL1;
      F_MUL1:  fstate_nxt = F_WGT;
      F_WGT:   fstate_nxt = F_MUL2;
      F_MUL2:  fstate_nxt = F_FRC;
      F_FRC:   fstate_nxt = F_IDLE;
      default: fstate_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fstate_r   <= F_IDLE;
      pos_r      <= '0;
      valid_r    <= '0;
      sum_r      <= '0;
      filtered_r <= '0;
      weight_r   <= '0;
      force_r    <= '0;
    end else begin
      fstate_r <= fstate_nxt;
      if (fstate_r == F_SUM) begin
        sum_r          <= sum_nxt;
        filtered_r     <= sum_nxt[RING_AW +: SAMPLE_BITS];
        valid_r[pos_r] <= 1'b1;
        pos_r          <= pos_r + RING_AW'(1);
      end
      if (fstate_r == F_WGT) begin
        weight_r <= sat_res(wsum);
      end
      if (fstate_r == F_FRC) begin
        force_r <= sat_res(fval);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fstate_r == F_MUL1) begin
      prod1_r <= slope * $signed({1'b0, filtered_r});
    end
    if (fstate_r == F_MUL2) begin
      prod2_r <= weight_r * $signed({1'b0, gain});
    end
  end

  assign st.busy   = (fstate_r != F_IDLE);
  assign st.done   = (fstate_r == F_FRC);
  assign filtered  = filtered_r;
  assign weight    = weight_r;
  assign force_val = force_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> fstate_r == F_IDLE)
    else $error("filter started while busy");
  a_sum_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    fstate_r == F_SUM |-> $past(start))
    else $error("ring update without a read");
`endif

endmodule

// File: sim/tb_load_cell_reader_moving_average.sv
// Testbench for the load cell reader: per-tick predictor and in-order scoreboard.
module tb_load_cell_reader_moving_average;
  timeunit 1ns;
  timeprecision 1ps;

  import lcrma_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam longint RES_MAX = (64'sd1 <<< (RES_W - 1)) - 1;
  localparam longint RES_MIN = -(64'sd1 <<< (RES_W - 1));

  typedef enum logic [1:0] {CAP_IDLE, CAP_LOW, CAP_HIGH} cap_phase_t;
  typedef enum int {BITS_RANDOM, BITS_ONES, BITS_ZEROS} bit_mode_t;

  typedef struct packed {
    logic                   clock_pin;
    logic                   report_valid;
    logic [23:0]            raw_value;
    logic [23:0]            filtered_value;
    logic signed [RES_W-1:0] weight_q8;
    logic signed [RES_W-1:0] force_q8;
  } reading_t;

  class reading_scoreboard;
    logic [7:0]              half_period;
    logic [23:0]             report_period;
    logic signed [23:0]      slope;
    logic signed [31:0]      offset;
    logic [23:0]             gain;

    cap_phase_t              phase;
    int                      half_cnt;
    int                      bit_cnt;
    logic [SAMPLE_BITS-1:0]  shift_word;
    logic [SAMPLE_BITS-1:0]  latest_raw;
    logic                    prev_level;
    logic [SAMPLE_BITS-1:0]  ring [FILTER_DEPTH];
    int                      ring_pos;
    logic [SUM_W-1:0]        sum;
    logic [23:0]             countdown;
    logic [23:0]             held_filtered;
    logic signed [RES_W-1:0] held_weight;
    logic signed [RES_W-1:0] held_force;

    reading_t awaited_readings [$];
    int ticks, reports, captures, readings, mismatches;

    function new();
      half_period   = RST_HALF_PERIOD;
      report_period = RST_REPORT_PERIOD;
      slope         = RST_SLOPE;
      offset        = RST_OFFSET;
      gain          = RST_FORCE_GAIN;
      phase         = CAP_IDLE;
      half_cnt      = 0;
      bit_cnt       = 0;
      shift_word    = '0;
      latest_raw    = '0;
      prev_level    = 1'b0;
      foreach (ring[i]) ring[i] = '0;
      ring_pos      = 0;
      sum           = '0;
      countdown     = RST_REPORT_PERIOD;
      held_filtered = '0;
      held_weight   = '0;
      held_force    = '0;
      ticks         = 0;
      reports       = 0;
      captures      = 0;
      readings      = 0;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_HALF_PERIOD:   half_period = data[7:0];
        CFG_REPORT_PERIOD: report_period = data[23:0];
        CFG_SLOPE:         slope = data[23:0];
        CFG_OFFSET:        offset = data;
        CFG_FORCE_GAIN:    gain = data[23:0];
        default: ;
      endcase
    endfunction

    function longint clamp_res(longint v);
      if (v > RES_MAX) return RES_MAX;
      if (v < RES_MIN) return RES_MIN;
      return v;
    endfunction

    function void accept_tick(logic d);
      int       half;
      reading_t r;
      longint   s, fl, g, w, f;
      half = (half_period == 0) ? 1 : half_period;
      r.clock_pin = 1'b0;
      r.report_valid = 1'b0;
      case (phase)
        CAP_LOW: begin
          half_cnt++;
          if (half_cnt >= half) begin
            half_cnt = 0;
            phase = CAP_HIGH;
          end
        end
        CAP_HIGH: begin
          r.clock_pin = 1'b1;
          half_cnt++;
          if (half_cnt >= half) begin
            half_cnt = 0;
            if (bit_cnt < SAMPLE_BITS) shift_word = {shift_word[SAMPLE_BITS-2:0], d};
            bit_cnt++;
            if (bit_cnt >= SAMPLE_BITS + 1) begin
              latest_raw = shift_word;
              bit_cnt = 0;
              phase = CAP_IDLE;
              captures++;
            end else begin
              phase = CAP_LOW;
            end
          end
        end
        default: begin
          if (prev_level && !d) begin
            phase = CAP_LOW;
            half_cnt = 0;
            bit_cnt = 0;
            shift_word = '0;
          end
        end
      endcase
      prev_level = d;

      if (countdown <= 1) begin
        countdown = (report_period == 0) ? 24'd1 : report_period;
        sum = sum - ring[ring_pos] + latest_raw;
        ring[ring_pos] = latest_raw;
        ring_pos = (ring_pos + 1) % FILTER_DEPTH;
        held_filtered = sum[SUM_W-1:RING_AW];
        s = slope;
        fl = held_filtered;
        g = gain;
        w = clamp_res(((s * fl + 64'sd32768) >>> 16) + longint'(offset));
        held_weight = w[RES_W-1:0];
        f = clamp_res((w * g + (64'sd1 <<< 23)) >>> 24);
        held_force = f[RES_W-1:0];
        r.report_valid = 1'b1;
        reports++;
      end else begin
        countdown--;
      end

      r.raw_value = latest_raw;
      r.filtered_value = held_filtered;
      r.weight_q8 = held_weight;
      r.force_q8 = held_force;
      awaited_readings.push_back(r);
      ticks++;
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      readings++;
      if (awaited_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result beat %0d arrived with no tick pending", readings);
        return;
      end
      want = awaited_readings.pop_front();
      if (got.clock_pin !== want.clock_pin || got.report_valid !== want.report_valid ||
          got.raw_value !== want.raw_value || got.filtered_value !== want.filtered_value ||
          got.weight_q8 !== want.weight_q8 || got.force_q8 !== want.force_q8) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: beat %0d exp clk=%b rpt=%b raw=%h filt=%h weight=%0d force=%0d",
                   readings, want.clock_pin, want.report_valid, want.raw_value,
                   want.filtered_value, want.weight_q8, want.force_q8);
          $display("       got clk=%b rpt=%b raw=%h filt=%h weight=%0d force=%0d",
                   got.clock_pin, got.report_valid, got.raw_value,
                   got.filtered_value, got.weight_q8, got.force_q8);
        end
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_data_pin;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_clock_pin;
  logic                    out_report_valid;
  logic [23:0]             out_raw_value;
  logic [23:0]             out_filtered_value;
  logic signed [33:0]      out_weight_q8;
  logic signed [33:0]      out_force_q8;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [31:0]             cfg_data;

  reading_scoreboard sb;
  bit relaxed;
  int reg_writes;

  load_cell_reader_moving_average dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_pin        (in_data_pin),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_clock_pin      (out_clock_pin),
    .out_report_valid   (out_report_valid),
    .out_raw_value      (out_raw_value),
    .out_filtered_value (out_filtered_value),
    .out_weight_q8      (out_weight_q8),
    .out_force_q8       (out_force_q8),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #10ns clk = ~clk;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (relaxed || roll < 65) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_reading({out_clock_pin, out_report_valid, out_raw_value,
                          out_filtered_value, out_weight_q8, out_force_q8});
      if (in_valid === 1'b1 && in_stall === 1'b0)
        sb.accept_tick(in_data_pin);
    end
  end

  initial begin : result_stall
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = pick_gap();
      if (hold == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
    end
  end

  task automatic send_tick(input logic d);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_pin <= d;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // drop in_valid, wait for every pending beat, then cover the report latency
  task automatic settle_outputs();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (sb.awaited_readings.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (12) @(negedge clk);
  endtask

  // one full conversion: wait out any capture, falling edge, then 25 pulses of data
  task automatic capture_word(input bit_mode_t mode);
    int n;
    while (sb.phase != CAP_IDLE) send_tick(1'($urandom_range(1)));
    n = 2 * (SAMPLE_BITS + 1) * ((sb.half_period == 0) ? 1 : sb.half_period);
    send_tick(1'b1);
    send_tick(1'b0);
    repeat (n) send_tick((mode == BITS_RANDOM) ? 1'($urandom_range(1)) : (mode == BITS_ONES));
  endtask

  initial begin : stimulus
    int          random_ticks;
    int          first_tick;
    int          roll;
    logic [31:0] value;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_pin = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_HALF_PERIOD;
    cfg_data = '0;
    relaxed = 1'b0;
    reg_writes = 0;
    sb = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cfg_write(CFG_SPARE_LO, 32'hFFFF_FFFF);
    cfg_write(CFG_SPARE_HI, $urandom());
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    capture_word(BITS_ONES);
    capture_word(BITS_RANDOM);
    settle_outputs();
    cfg_write(CFG_HALF_PERIOD, 32'd0);
    capture_word(BITS_ZEROS);
    capture_word(BITS_ONES);

    // run out the reset countdown; data held high never starts a capture
    settle_outputs();
    cfg_write(CFG_REPORT_PERIOD, 32'd0);
    cfg_write(CFG_SLOPE, 32'h007F_FFFF);
    cfg_write(CFG_OFFSET, 32'h7FFF_FFFF);
    cfg_write(CFG_FORCE_GAIN, 32'h00FF_FFFF);
    relaxed = 1'b1;
    while (sb.reports == 0) send_tick(1'b1);
    repeat (20) send_tick(1'b1);

    settle_outputs();
    cfg_write(CFG_REPORT_PERIOD, 32'h00FF_FFFF);
    cfg_write(CFG_REPORT_PERIOD, 32'd1);
    cfg_write(CFG_SLOPE, 32'h0080_0000);
    cfg_write(CFG_OFFSET, 32'h8000_0000);
    repeat (20) send_tick(1'b1);
    capture_word(BITS_RANDOM);

    settle_outputs();
    cfg_write(CFG_HALF_PERIOD, 32'd255);
    cfg_write(CFG_REPORT_PERIOD, 32'd1000);
    cfg_write(CFG_FORCE_GAIN, 32'd0);
    capture_word(BITS_RANDOM);

    random_ticks = 0;
    while (random_ticks < 1250) begin
      settle_outputs();
      relaxed = 1'b0;
      if (sb.half_period > 8 || $urandom_range(1)) begin
        roll = $urandom_range(9);
        value = $urandom();
        value[7:0] = (roll < 1) ? 8'd0 : (roll < 6) ? 8'd1 : 8'($urandom_range(6, 2));
        cfg_write(CFG_HALF_PERIOD, value);
      end
      if ($urandom_range(1)) begin
        roll = $urandom_range(9);
        value = $urandom();
        value[23:0] = (roll < 1) ? 24'd0 : (roll < 2) ? 24'd1 :
                      (roll < 8) ? 24'($urandom_range(40, 2)) : 24'($urandom_range(400, 41));
        if ($urandom_range(7) == 0) cfg_write(CFG_REPORT_PERIOD, 32'h00FF_FFFF);
        cfg_write(CFG_REPORT_PERIOD, value);
      end
      if ($urandom_range(1)) begin
        roll = $urandom_range(9);
        value = $urandom();
        if (roll == 0) value[23:0] = 24'h80_0000;
        else if (roll == 1) value[23:0] = 24'h7F_FFFF;
        cfg_write(CFG_SLOPE, value);
      end
      if ($urandom_range(1)) begin
        roll = $urandom_range(9);
        value = $urandom();
        if (roll == 0) value = 32'h8000_0000;
        else if (roll == 1) value = 32'h7FFF_FFFF;
        cfg_write(CFG_OFFSET, value);
      end
      if ($urandom_range(1)) begin
        roll = $urandom_range(9);
        value = $urandom();
        if (roll == 0) value[23:0] = 24'h00_0000;
        else if (roll == 1) value[23:0] = 24'hFF_FFFF;
        cfg_write(CFG_FORCE_GAIN, value);
      end
      relaxed = ($urandom_range(4) == 0);
      first_tick = sb.ticks;
      repeat ($urandom_range(4, 1)) begin
        roll = $urandom_range(9);
        if (roll < 5) capture_word(BITS_RANDOM);
        else if (roll < 7) capture_word(BITS_ONES);
        else if (roll < 8) capture_word(BITS_ZEROS);
        else repeat ($urandom_range(30, 1)) send_tick(1'($urandom_range(1)));
      end
      random_ticks += sb.ticks - first_tick;
    end

    settle_outputs();
    if (sb.awaited_readings.size() != 0) begin
      $display("ERROR: %0d result beats never arrived", sb.awaited_readings.size());
      sb.mismatches += sb.awaited_readings.size();
    end
    $display("Run covered %0d ticks with %0d finished conversions and %0d filter updates,",
             sb.ticks, sb.captures, sb.reports);
    $display("across %0d register writes; %0d result beats checked.", reg_writes, sb.readings);
    if (sb.mismatches == 0) begin
      $display("tb_load_cell_reader_moving_average: done, clean");
    end else begin
      $display("tb_load_cell_reader_moving_average: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("ERROR: run timed out");
    $display("tb_load_cell_reader_moving_average: done, errors");
    $finish;
  end

endmodule
